/* rtl/rvid_pkg.sv */
// shared types, opcodes and instruction numbers for the rv64 instruction decoder
`timescale 1ns / 1ps

package rvid_pkg;

    // encoding formats
    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_I    = 3'd1,
        FMT_S    = 3'd2,
        FMT_B    = 3'd3,
        FMT_U    = 3'd4,
        FMT_J    = 3'd5,
        FMT_R    = 3'd6
    } fmt_t;

    // dense instruction numbers, zero marks an invalid word
    typedef enum logic [5:0] {
        ID_INVALID = 6'd0,
        ID_LD      = 6'd1,
        ID_LH      = 6'd2,
        ID_LHU     = 6'd3,
        ID_LW      = 6'd4,
        ID_LBU     = 6'd5,
        ID_SD      = 6'd6,
        ID_SB      = 6'd7,
        ID_SH      = 6'd8,
        ID_SW      = 6'd9,
        ID_BEQ     = 6'd10,
        ID_BNE     = 6'd11,
        ID_BLT     = 6'd12,
        ID_BLTU    = 6'd13,
        ID_BGE     = 6'd14,
        ID_ADDI    = 6'd15,
        ID_SLLI    = 6'd16,
        ID_SRLI    = 6'd17,
        ID_SRAI    = 6'd18,
        ID_SLTIU   = 6'd19,
        ID_ANDI    = 6'd20,
        ID_XORI    = 6'd21,
        ID_ADDIW   = 6'd22,
        ID_SLLIW   = 6'd23,
        ID_SRLIW   = 6'd24,
        ID_SRAIW   = 6'd25,
        ID_ADD     = 6'd26,
        ID_SUB     = 6'd27,
        ID_SLT     = 6'd28,
        ID_SLTU    = 6'd29,
        ID_AND     = 6'd30,
        ID_MUL     = 6'd31,
        ID_OR      = 6'd32,
        ID_ADDW    = 6'd33,
        ID_SUBW    = 6'd34,
        ID_MULW    = 6'd35,
        ID_DIVW    = 6'd36,
        ID_REMW    = 6'd37,
        ID_SLLW    = 6'd38,
        ID_SRLW    = 6'd39,
        ID_SRAW    = 6'd40,
        ID_JALR    = 6'd41,
        ID_AUIPC   = 6'd42,
        ID_LUI     = 6'd43,
        ID_JAL     = 6'd44,
        ID_TRAP    = 6'd45
    } instr_id_t;

    // major opcodes, bits 6:0
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_IMM32  = 7'h1B;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_REG32  = 7'h3B;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_TRAP   = 7'h6B;

    // funct7 / funct6 selectors
    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [5:0] F6_BASE   = 6'h00;
    localparam logic [5:0] F6_ALT    = 6'h10;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned OUT_W   = 64;
    localparam int unsigned RES_W   = 57;

    // match stage result
    typedef struct packed {
        instr_id_t id;
        fmt_t      fmt;
    } match_t;

    // full decode result, lowest field in the lowest bits
    typedef struct packed {
        logic        rd_writes;
        logic [31:0] imm;
        logic [4:0]  rd;
        logic [4:0]  rs2;
        logic [4:0]  rs1;
        fmt_t        fmt;
        instr_id_t   id;
    } result_t;

endpackage

/* rtl/rvid_match.sv */
// opcode and function field matching: instruction number and format
`timescale 1ns / 1ps

module rvid_match
(
    input  logic [31:0]     word,
    output rvid_pkg::match_t mres
);

    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [5:0] f6;
    rvid_pkg::instr_id_t id;
    rvid_pkg::fmt_t      fmt;

    assign op = word[6:0];
    assign f3 = word[14:12];
    assign f7 = word[31:25];
    assign f6 = word[31:26];

    // opcode table
    always_comb
    begin
        id  = rvid_pkg::ID_INVALID;
        fmt = rvid_pkg::FMT_NONE;
        case (op)
            rvid_pkg::OP_LOAD:
            begin
                fmt = rvid_pkg::FMT_I;
                case (f3)
                    3'd3:    id = rvid_pkg::ID_LD;
                    3'd1:    id = rvid_pkg::ID_LH;
                    3'd5:    id = rvid_pkg::ID_LHU;
                    3'd2:    id = rvid_pkg::ID_LW;
                    3'd4:    id = rvid_pkg::ID_LBU;
                    default: id = rvid_pkg::ID_INVALID;
                endcase
            end
            rvid_pkg::OP_STORE:
            begin
                fmt = rvid_pkg::FMT_S;
                case (f3)
                    3'd3:    id = rvid_pkg::ID_SD;
                    3'd0:    id = rvid_pkg::ID_SB;
                    3'd1:    id = rvid_pkg::ID_SH;
                    3'd2:    id = rvid_pkg::ID_SW;
                    default: id = rvid_pkg::ID_INVALID;
                endcase
            end
            rvid_pkg::OP_BRANCH:
            begin
                fmt = rvid_pkg::FMT_B;
                case (f3)
                    3'd0:    id = rvid_pkg::ID_BEQ;
                    3'd1:    id = rvid_pkg::ID_BNE;
                    3'd4:    id = rvid_pkg::ID_BLT;
                    3'd6:    id = rvid_pkg::ID_BLTU;
                    3'd5:    id = rvid_pkg::ID_BGE;
                    default: id = rvid_pkg::ID_INVALID;
                endcase
            end
            rvid_pkg::OP_IMM:
            begin
                fmt = rvid_pkg::FMT_I;
                case (f3)
                    3'd0:    id = rvid_pkg::ID_ADDI;
                    3'd1:    id = (f6 == rvid_pkg::F6_BASE) ? rvid_pkg::ID_SLLI
                                                            : rvid_pkg::ID_INVALID;
                    3'd5:
                    begin
                        if (f6 == rvid_pkg::F6_BASE)
                            id = rvid_pkg::ID_SRLI;
                        else if (f6 == rvid_pkg::F6_ALT)
                            id = rvid_pkg::ID_SRAI;
                        else
                            id = rvid_pkg::ID_INVALID;
                    end
                    3'd3:    id = rvid_pkg::ID_SLTIU;
                    3'd7:    id = rvid_pkg::ID_ANDI;
                    3'd4:    id = rvid_pkg::ID_XORI;
                    default: id = rvid_pkg::ID_INVALID;
                endcase
            end
            rvid_pkg::OP_IMM32:
            begin
                fmt = rvid_pkg::FMT_I;
                case (f3)
                    3'd0:    id = rvid_pkg::ID_ADDIW;
                    3'd1:    id = (f7 == rvid_pkg::F7_BASE) ? rvid_pkg::ID_SLLIW
                                                            : rvid_pkg::ID_INVALID;
                    3'd5:
                    begin
                        if (f7 == rvid_pkg::F7_BASE)
                            id = rvid_pkg::ID_SRLIW;
                        else if (f7 == rvid_pkg::F7_ALT)
                            id = rvid_pkg::ID_SRAIW;
                        else
                            id = rvid_pkg::ID_INVALID;
                    end
                    default: id = rvid_pkg::ID_INVALID;
                endcase
            end
            rvid_pkg::OP_REG:
            begin
                fmt = rvid_pkg::FMT_R;
                if (f7 == rvid_pkg::F7_BASE)
                begin
                    case (f3)
                        3'd0:    id = rvid_pkg::ID_ADD;
                        3'd2:    id = rvid_pkg::ID_SLT;
                        3'd3:    id = rvid_pkg::ID_SLTU;
                        3'd7:    id = rvid_pkg::ID_AND;
                        3'd6:    id = rvid_pkg::ID_OR;
                        default: id = rvid_pkg::ID_INVALID;
                    endcase
                end
                else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd0)
                    id = rvid_pkg::ID_SUB;
                else if (f7 == rvid_pkg::F7_MULDIV && f3 == 3'd0)
                    id = rvid_pkg::ID_MUL;
                else
                    id = rvid_pkg::ID_INVALID;
            end
            rvid_pkg::OP_REG32:
            begin
                fmt = rvid_pkg::FMT_R;
                if (f7 == rvid_pkg::F7_BASE)
                begin
                    case (f3)
                        3'd0:    id = rvid_pkg::ID_ADDW;
                        3'd1:    id = rvid_pkg::ID_SLLW;
                        3'd5:    id = rvid_pkg::ID_SRLW;
                        default: id = rvid_pkg::ID_INVALID;
                    endcase
                end
                else if (f7 == rvid_pkg::F7_ALT)
                begin
                    case (f3)
                        3'd0:    id = rvid_pkg::ID_SUBW;
                        3'd5:    id = rvid_pkg::ID_SRAW;
                        default: id = rvid_pkg::ID_INVALID;
                    endcase
                end
                else if (f7 == rvid_pkg::F7_MULDIV)
                begin
                    case (f3)
                        3'd0:    id = rvid_pkg::ID_MULW;
                        3'd4:    id = rvid_pkg::ID_DIVW;
                        3'd6:    id = rvid_pkg::ID_REMW;
                        default: id = rvid_pkg::ID_INVALID;
                    endcase
                end
                else
                    id = rvid_pkg::ID_INVALID;
            end
            rvid_pkg::OP_JALR:
            begin
                fmt = rvid_pkg::FMT_I;
                id  = (f3 == 3'd0) ? rvid_pkg::ID_JALR : rvid_pkg::ID_INVALID;
            end
            rvid_pkg::OP_AUIPC:
            begin
                fmt = rvid_pkg::FMT_U;
                id  = rvid_pkg::ID_AUIPC;
            end
            rvid_pkg::OP_LUI:
            begin
                fmt = rvid_pkg::FMT_U;
                id  = rvid_pkg::ID_LUI;
            end
            rvid_pkg::OP_JAL:
            begin
                fmt = rvid_pkg::FMT_J;
                id  = rvid_pkg::ID_JAL;
            end
            rvid_pkg::OP_TRAP:
            begin
                fmt = rvid_pkg::FMT_NONE;
                id  = rvid_pkg::ID_TRAP;
            end
            default:
            begin
                fmt = rvid_pkg::FMT_NONE;
                id  = rvid_pkg::ID_INVALID;
            end
        endcase
    end

    // invalid words and the trap carry no format
    always_comb
    begin
        mres.id  = id;
        mres.fmt = (id == rvid_pkg::ID_INVALID || id == rvid_pkg::ID_TRAP)
                   ? rvid_pkg::FMT_NONE : fmt;
    end

endmodule

/* rtl/rvid_fields.sv */
// register index selection, immediate assembly and write enable
`timescale 1ns / 1ps

module rvid_fields
(
    input  logic [31:0]       word,
    input  rvid_pkg::match_t  mres,
    output rvid_pkg::result_t res
);

    logic       use_rs1;
    logic       use_rs2;
    logic       use_rd;
    logic       sgn;
    logic [31:0] imm;

    assign sgn = word[31];

    // which register fields the format uses
    always_comb
    begin
        use_rs1 = 1'b0;
        use_rs2 = 1'b0;
        use_rd  = 1'b0;
        case (mres.fmt)
            rvid_pkg::FMT_I:
            begin
                use_rs1 = 1'b1;
                use_rd  = 1'b1;
            end
            rvid_pkg::FMT_S, rvid_pkg::FMT_B:
            begin
                use_rs1 = 1'b1;
                use_rs2 = 1'b1;
            end
            rvid_pkg::FMT_U, rvid_pkg::FMT_J:
            begin
                use_rd = 1'b1;
            end
            rvid_pkg::FMT_R:
            begin
                use_rs1 = 1'b1;
                use_rs2 = 1'b1;
                use_rd  = 1'b1;
            end
            default:
            begin
                use_rs1 = 1'b0;
                use_rs2 = 1'b0;
                use_rd  = 1'b0;
            end
        endcase
    end

    // immediate per format
    always_comb
    begin
        case (mres.fmt)
            rvid_pkg::FMT_I: imm = {{20{sgn}}, word[31:20]};
            rvid_pkg::FMT_S: imm = {{20{sgn}}, word[31:25], word[11:7]};
            rvid_pkg::FMT_B: imm = {{20{sgn}}, word[7], word[30:25], word[11:8], 1'b0};
            rvid_pkg::FMT_U: imm = {word[31:12], 12'd0};
            rvid_pkg::FMT_J: imm = {{12{sgn}}, word[19:12], word[20], word[30:21], 1'b0};
            default:         imm = 32'd0;
        endcase
    end

    // assemble the result, no write to x0
    always_comb
    begin
        res.id        = mres.id;
        res.fmt       = mres.fmt;
        res.rs1       = use_rs1 ? word[19:15] : 5'd0;
        res.rs2       = use_rs2 ? word[24:20] : 5'd0;
        res.rd        = use_rd  ? word[11:7]  : 5'd0;
        res.imm       = imm;
        res.rd_writes = use_rd && (word[11:7] != 5'd0);
    end

endmodule

/* rtl/rv64_instruction_decoder_unit.sv */
// top level: three stage rv64 instruction decode pipeline with stream ports
// each word passes through the stage one, stage two and output registers before its result
// shows on m_tvalid, and a stall on m_tready holds it where it is
// throughput: one instruction word per cycle while m_tready stays high, each stage
// advances when empty or when the stage after it moves on
// reset: rst_n clears all stage valid bits asynchronously, payload is not reset
`timescale 1ns / 1ps

module rv64_instruction_decoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] instr_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [5:0] instr_id, [8:6] format, [13:9] rs1,
                                   // [18:14] rs2, [23:19] rd, [55:24] imm,
                                   // [56] rd_writes, [63:57] zero
);

    logic               s1_valid_reg;
    logic [31:0]        s1_word_reg;
    logic               s2_valid_reg;
    logic [31:0]        s2_word_reg;
    rvid_pkg::match_t   s2_match_reg;
    logic               s3_valid_reg;
    rvid_pkg::result_t  s3_res_reg;

    rvid_pkg::match_t   s1_match;
    rvid_pkg::result_t  s2_res;
    logic               s1_ready;
    logic               s2_ready;
    logic               s3_ready;

    // per-stage advance, a stage takes new data when empty or draining
    assign s3_ready = !s3_valid_reg || m_tready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= s_tvalid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage one: capture the instruction word
    always_ff @(posedge clk)
    begin
        if (s1_ready)
            s1_word_reg <= s_tdata;
    end

    rvid_match u_match
    (
        .word (s1_word_reg),
        .mres (s1_match)
    );

    // stage two: instruction number and format
    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_word_reg  <= s1_word_reg;
            s2_match_reg <= s1_match;
        end
    end

    rvid_fields u_fields
    (
        .word (s2_word_reg),
        .mres (s2_match_reg),
        .res  (s2_res)
    );

    // stage three: output register
    always_ff @(posedge clk)
    begin
        if (s3_ready)
            s3_res_reg <= s2_res;
    end

    assign m_tvalid = s3_valid_reg;
    assign m_tdata  = {{(rvid_pkg::OUT_W - rvid_pkg::RES_W){1'b0}}, s3_res_reg};

endmodule

/* rtl/rvid_checker.sv */
// port-level checks on the rv64 instruction decoder and their binding
`timescale 1ns / 1ps

module rvid_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an accepted request reaches the output when m_tready lets it through the stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after pipeline latency");

    // no write reported for x0
    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[56] |-> m_tdata[23:19] != 5'd0)
        else $error("write reported for x0");

    // invalid words and the trap carry nothing but their number
    a_bare_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[5:0] == rvid_pkg::ID_INVALID
                     || m_tdata[5:0] == rvid_pkg::ID_TRAP)
        |-> m_tdata[63:6] == 58'd0)
        else $error("invalid or trap result carries fields");

endmodule

bind rv64_instruction_decoder_unit rvid_checker u_rvid_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* verif/testbench.sv */
// stream-level test of the rv64 instruction decoder against a local decode model
`timescale 1ns / 1ps

module testbench;

    import rvid_pkg::*;

    // funct3 codes, grouped by major opcode
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LD   = 3'd3;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;
    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SH   = 3'd1;
    localparam logic [2:0] F3_SW   = 3'd2;
    localparam logic [2:0] F3_SD   = 3'd3;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_MUL  = 3'd0;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_REM  = 3'd6;
    localparam logic [2:0] F3_JALR = 3'd0;

    localparam int ID_LAST     = 45;
    localparam int RANDOM_REQS = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    // expected decode results, one per accepted instruction word
    class decode_checker;
        result_t expected_decodes[$];
        int      mismatches;

        function new();
            mismatches = 0;
        endfunction

        // decode of one word, bit for bit
        function result_t decode_word(logic [31:0] w);
            result_t    r;
            instr_id_t  id;
            fmt_t       fmt;
            logic [6:0] op;
            logic [2:0] f3;
            logic [6:0] f7;
            logic [5:0] f6;
            logic       has_rs1;
            logic       has_rs2;
            logic       has_rd;
            op  = w[6:0];
            f3  = w[14:12];
            f7  = w[31:25];
            f6  = w[31:26];
            id  = ID_INVALID;
            fmt = FMT_NONE;
            case (op)
                OP_LOAD:
                begin
                    fmt = FMT_I;
                    case (f3)
                        F3_LD:   id = ID_LD;
                        F3_LH:   id = ID_LH;
                        F3_LHU:  id = ID_LHU;
                        F3_LW:   id = ID_LW;
                        F3_LBU:  id = ID_LBU;
                        default: id = ID_INVALID;
                    endcase
                end
                OP_STORE:
                begin
                    fmt = FMT_S;
                    case (f3)
                        F3_SD:   id = ID_SD;
                        F3_SB:   id = ID_SB;
                        F3_SH:   id = ID_SH;
                        F3_SW:   id = ID_SW;
                        default: id = ID_INVALID;
                    endcase
                end
                OP_BRANCH:
                begin
                    fmt = FMT_B;
                    case (f3)
                        F3_BEQ:  id = ID_BEQ;
                        F3_BNE:  id = ID_BNE;
                        F3_BLT:  id = ID_BLT;
                        F3_BLTU: id = ID_BLTU;
                        F3_BGE:  id = ID_BGE;
                        default: id = ID_INVALID;
                    endcase
                end
                OP_IMM:
                begin
                    fmt = FMT_I;
                    if (f3 == F3_ADD) id = ID_ADDI;
                    else if (f3 == F3_SLL && f6 == F6_BASE) id = ID_SLLI;
                    else if (f3 == F3_SR && f6 == F6_BASE) id = ID_SRLI;
                    else if (f3 == F3_SR && f6 == F6_ALT) id = ID_SRAI;
                    else if (f3 == F3_SLTU) id = ID_SLTIU;
                    else if (f3 == F3_AND) id = ID_ANDI;
                    else if (f3 == F3_XOR) id = ID_XORI;
                end
                OP_IMM32:
                begin
                    fmt = FMT_I;
                    if (f3 == F3_ADD) id = ID_ADDIW;
                    else if (f3 == F3_SLL && f7 == F7_BASE) id = ID_SLLIW;
                    else if (f3 == F3_SR && f7 == F7_BASE) id = ID_SRLIW;
                    else if (f3 == F3_SR && f7 == F7_ALT) id = ID_SRAIW;
                end
                OP_REG:
                begin
                    fmt = FMT_R;
                    if (f7 == F7_BASE && f3 == F3_ADD) id = ID_ADD;
                    else if (f7 == F7_ALT && f3 == F3_ADD) id = ID_SUB;
                    else if (f7 == F7_BASE && f3 == F3_SLT) id = ID_SLT;
                    else if (f7 == F7_BASE && f3 == F3_SLTU) id = ID_SLTU;
                    else if (f7 == F7_BASE && f3 == F3_AND) id = ID_AND;
                    else if (f7 == F7_MULDIV && f3 == F3_MUL) id = ID_MUL;
                    else if (f7 == F7_BASE && f3 == F3_OR) id = ID_OR;
                end
                OP_REG32:
                begin
                    fmt = FMT_R;
                    if (f7 == F7_BASE && f3 == F3_ADD) id = ID_ADDW;
                    else if (f7 == F7_ALT && f3 == F3_ADD) id = ID_SUBW;
                    else if (f7 == F7_MULDIV && f3 == F3_MUL) id = ID_MULW;
                    else if (f7 == F7_MULDIV && f3 == F3_DIV) id = ID_DIVW;
                    else if (f7 == F7_MULDIV && f3 == F3_REM) id = ID_REMW;
                    else if (f7 == F7_BASE && f3 == F3_SLL) id = ID_SLLW;
                    else if (f7 == F7_BASE && f3 == F3_SR) id = ID_SRLW;
                    else if (f7 == F7_ALT && f3 == F3_SR) id = ID_SRAW;
                end
                OP_JALR:
                begin
                    fmt = FMT_I;
                    if (f3 == F3_JALR) id = ID_JALR;
                end
                OP_AUIPC:
                begin
                    fmt = FMT_U;
                    id  = ID_AUIPC;
                end
                OP_LUI:
                begin
                    fmt = FMT_U;
                    id  = ID_LUI;
                end
                OP_JAL:
                begin
                    fmt = FMT_J;
                    id  = ID_JAL;
                end
                OP_TRAP:  id = ID_TRAP;
                default:  id = ID_INVALID;
            endcase
            if (id == ID_INVALID || id == ID_TRAP)
                fmt = FMT_NONE;

            has_rs1 = (fmt == FMT_I || fmt == FMT_S || fmt == FMT_B || fmt == FMT_R);
            has_rs2 = (fmt == FMT_S || fmt == FMT_B || fmt == FMT_R);
            has_rd  = (fmt == FMT_I || fmt == FMT_U || fmt == FMT_J || fmt == FMT_R);

            r.id  = id;
            r.fmt = fmt;
            r.rs1 = has_rs1 ? w[19:15] : 5'd0;
            r.rs2 = has_rs2 ? w[24:20] : 5'd0;
            r.rd  = has_rd ? w[11:7] : 5'd0;
            case (fmt)
                FMT_I:   r.imm = {{20{w[31]}}, w[31:20]};
                FMT_S:   r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
                FMT_B:   r.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                FMT_U:   r.imm = {w[31:12], 12'd0};
                FMT_J:   r.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                default: r.imm = 32'd0;
            endcase
            r.rd_writes = has_rd && (w[11:7] != 5'd0);
            return r;
        endfunction

        function void note_word(logic [31:0] w);
            expected_decodes.push_back(decode_word(w));
        endfunction

        function void check_decode(result_t got);
            result_t want;
            if (expected_decodes.size() == 0)
            begin
                $error("decode result with no request outstanding: %h", got);
                mismatches++;
                return;
            end
            want = expected_decodes.pop_front();
            if (got.id !== want.id)
            begin
                $error("instr_id: expected %0d, actual %0d", want.id, got.id);
                mismatches++;
            end
            if (got.fmt !== want.fmt)
            begin
                $error("format: expected %0d, actual %0d", want.fmt, got.fmt);
                mismatches++;
            end
            if (got.rs1 !== want.rs1)
            begin
                $error("rs1: expected %0d, actual %0d", want.rs1, got.rs1);
                mismatches++;
            end
            if (got.rs2 !== want.rs2)
            begin
                $error("rs2: expected %0d, actual %0d", want.rs2, got.rs2);
                mismatches++;
            end
            if (got.rd !== want.rd)
            begin
                $error("rd: expected %0d, actual %0d", want.rd, got.rd);
                mismatches++;
            end
            if (got.imm !== want.imm)
            begin
                $error("imm: expected %h, actual %h", want.imm, got.imm);
                mismatches++;
            end
            if (got.rd_writes !== want.rd_writes)
            begin
                $error("rd_writes: expected %0d, actual %0d", want.rd_writes, got.rd_writes);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_decodes.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;   // [31:0] instr_word
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // [5:0] instr_id, [8:6] format, [13:9] rs1,
                                    // [18:14] rs2, [23:19] rd, [55:24] imm,
                                    // [56] rd_writes

    decode_checker checker_h;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            stall_cycles = 0;

    rv64_instruction_decoder_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // one request, with random idle cycles in front of it
    task automatic send_word(input logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
        checker_h.note_word(w);
    endtask

    // well-formed word for a given instruction, other bits random
    function automatic logic [31:0] encode_instr(instr_id_t id);
        logic [31:0] w;
        logic [6:0]  op;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic        set_f3;
        logic        set_f7;
        logic        set_f6;
        w      = $urandom;
        op     = OP_TRAP;
        f3     = F3_ADD;
        f7     = F7_BASE;
        set_f3 = 1'b1;
        set_f7 = 1'b0;
        set_f6 = 1'b0;
        case (id)
            ID_LD:    begin op = OP_LOAD;   f3 = F3_LD;   end
            ID_LH:    begin op = OP_LOAD;   f3 = F3_LH;   end
            ID_LHU:   begin op = OP_LOAD;   f3 = F3_LHU;  end
            ID_LW:    begin op = OP_LOAD;   f3 = F3_LW;   end
            ID_LBU:   begin op = OP_LOAD;   f3 = F3_LBU;  end
            ID_SD:    begin op = OP_STORE;  f3 = F3_SD;   end
            ID_SB:    begin op = OP_STORE;  f3 = F3_SB;   end
            ID_SH:    begin op = OP_STORE;  f3 = F3_SH;   end
            ID_SW:    begin op = OP_STORE;  f3 = F3_SW;   end
            ID_BEQ:   begin op = OP_BRANCH; f3 = F3_BEQ;  end
            ID_BNE:   begin op = OP_BRANCH; f3 = F3_BNE;  end
            ID_BLT:   begin op = OP_BRANCH; f3 = F3_BLT;  end
            ID_BLTU:  begin op = OP_BRANCH; f3 = F3_BLTU; end
            ID_BGE:   begin op = OP_BRANCH; f3 = F3_BGE;  end
            ID_ADDI:  begin op = OP_IMM;    f3 = F3_ADD;  end
            ID_SLLI:  begin op = OP_IMM; f3 = F3_SLL; set_f6 = 1'b1; f7 = {F6_BASE, 1'b0}; end
            ID_SRLI:  begin op = OP_IMM; f3 = F3_SR;  set_f6 = 1'b1; f7 = {F6_BASE, 1'b0}; end
            ID_SRAI:  begin op = OP_IMM; f3 = F3_SR;  set_f6 = 1'b1; f7 = {F6_ALT, 1'b0};  end
            ID_SLTIU: begin op = OP_IMM;    f3 = F3_SLTU; end
            ID_ANDI:  begin op = OP_IMM;    f3 = F3_AND;  end
            ID_XORI:  begin op = OP_IMM;    f3 = F3_XOR;  end
            ID_ADDIW: begin op = OP_IMM32;  f3 = F3_ADD;  end
            ID_SLLIW: begin op = OP_IMM32; f3 = F3_SLL; set_f7 = 1'b1; f7 = F7_BASE; end
            ID_SRLIW: begin op = OP_IMM32; f3 = F3_SR;  set_f7 = 1'b1; f7 = F7_BASE; end
            ID_SRAIW: begin op = OP_IMM32; f3 = F3_SR;  set_f7 = 1'b1; f7 = F7_ALT;  end
            ID_ADD:   begin op = OP_REG;   f3 = F3_ADD;  set_f7 = 1'b1; f7 = F7_BASE;   end
            ID_SUB:   begin op = OP_REG;   f3 = F3_ADD;  set_f7 = 1'b1; f7 = F7_ALT;    end
            ID_SLT:   begin op = OP_REG;   f3 = F3_SLT;  set_f7 = 1'b1; f7 = F7_BASE;   end
            ID_SLTU:  begin op = OP_REG;   f3 = F3_SLTU; set_f7 = 1'b1; f7 = F7_BASE;   end
            ID_AND:   begin op = OP_REG;   f3 = F3_AND;  set_f7 = 1'b1; f7 = F7_BASE;   end
            ID_MUL:   begin op = OP_REG;   f3 = F3_MUL;  set_f7 = 1'b1; f7 = F7_MULDIV; end
            ID_OR:    begin op = OP_REG;   f3 = F3_OR;   set_f7 = 1'b1; f7 = F7_BASE;   end
            ID_ADDW:  begin op = OP_REG32; f3 = F3_ADD;  set_f7 = 1'b1; f7 = F7_BASE;   end
            ID_SUBW:  begin op = OP_REG32; f3 = F3_ADD;  set_f7 = 1'b1; f7 = F7_ALT;    end
            ID_MULW:  begin op = OP_REG32; f3 = F3_MUL;  set_f7 = 1'b1; f7 = F7_MULDIV; end
            ID_DIVW:  begin op = OP_REG32; f3 = F3_DIV;  set_f7 = 1'b1; f7 = F7_MULDIV; end
            ID_REMW:  begin op = OP_REG32; f3 = F3_REM;  set_f7 = 1'b1; f7 = F7_MULDIV; end
            ID_SLLW:  begin op = OP_REG32; f3 = F3_SLL;  set_f7 = 1'b1; f7 = F7_BASE;   end
            ID_SRLW:  begin op = OP_REG32; f3 = F3_SR;   set_f7 = 1'b1; f7 = F7_BASE;   end
            ID_SRAW:  begin op = OP_REG32; f3 = F3_SR;   set_f7 = 1'b1; f7 = F7_ALT;    end
            ID_JALR:  begin op = OP_JALR;   f3 = F3_JALR; end
            ID_AUIPC: begin op = OP_AUIPC;  set_f3 = 1'b0; end
            ID_LUI:   begin op = OP_LUI;    set_f3 = 1'b0; end
            ID_JAL:   begin op = OP_JAL;    set_f3 = 1'b0; end
            default:  begin op = OP_TRAP;   set_f3 = 1'b0; end
        endcase
        w[6:0] = op;
        if (set_f3)
            w[14:12] = f3;
        if (set_f7)
            w[31:25] = f7;
        if (set_f6)
            w[31:26] = f7[6:1];
        return w;
    endfunction

    // random word: mostly well-formed, some with broken selectors, some pure noise
    function automatic logic [31:0] random_word(int n);
        logic [31:0] w;
        int          pick;
        pick = $urandom_range(99);
        if (n < ID_LAST)
            w = encode_instr(instr_id_t'(n + 1));
        else
            w = encode_instr(instr_id_t'($urandom_range(ID_LAST, 1)));
        if (n >= ID_LAST && pick >= 75 && pick < 82)
            w[14:12] = 3'($urandom);
        else if (n >= ID_LAST && pick >= 82 && pick < 88)
            w[31:25] = 7'($urandom);
        else if (n >= ID_LAST && pick >= 88 && pick < 91)
            w[1:0] = 2'($urandom);
        else if (n >= ID_LAST && pick >= 91)
            w = $urandom;
        // x0 as destination now and then
        if ($urandom_range(7) == 0)
            w[11:7] = 5'd0;
        return w;
    endfunction

    // result side: check, random back-pressure, watchdog
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            checker_h.check_decode(result_t'(m_tdata[RES_W-1:0]));
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("rv64_instruction_decoder_unit test failed");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        logic [31:0] directed_words[$];
        int          n;
        checker_h = new();
        directed_words = '{
            32'h0000_0000,  // all zero, low bits not 11
            32'hFFFF_FFFF,  // all ones, unknown opcode
            32'h0000_3001,  // load opcode but low bits 01
            32'h0000_006B,  // trap opcode, rest zero
            32'hFFFF_FFEB,  // trap opcode, rest ones
            32'h0000_0013,  // addi x0: no register write
            32'h7FF0_0013,  // largest positive I immediate
            32'h8000_0013,  // most negative I immediate
            32'hFFFF_FF93,  // andi with imm -1
            32'h43F0_D093,  // srai by 63
            32'h0200_9093,  // slli by 32
            32'h41F0_D09B,  // sraiw by 31
            32'h0200_909B,  // slliw with shamt bit 5 set: invalid
            32'h0000_0033,  // add x0: no write on R format
            32'h41FF_8FB3,  // sub x31
            32'hFE00_0033,  // unknown funct7 on R format
            32'h0200_62BB,  // remw
            32'hFFFF_BFA3,  // sd with imm -1
            32'h0000_4023,  // store with unknown funct3
            32'hFFFF_8FE3,  // beq with all-ones offset
            32'h0000_2063,  // branch with unknown funct3
            32'hFFFF_FFB7,  // lui with all ones
            32'h0000_0017,  // auipc x0
            32'hFFFF_FFEF,  // jal with all-ones offset
            32'h7FFF_F0EF,  // jal with largest positive offset
            32'h0000_1067,  // jalr with unknown funct3
            32'h0000_80E7   // jalr
        };

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // three phases of idling: sender-light, receiver-light, none
        n = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 73 : 0;
            recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 29 : 0;
            if (phase == 0)
                foreach (directed_words[k])
                    send_word(directed_words[k]);
            for (int k = 0; k < RANDOM_REQS / 3 + 1; k++)
            begin
                send_word(random_word(n));
                n++;
            end
        end
        s_tvalid <= 1'b0;

        // drain
        while (checker_h.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (checker_h.mismatches == 0)
            $display("rv64_instruction_decoder_unit test passed");
        else
            $display("rv64_instruction_decoder_unit test failed");
        $finish;
    end

endmodule
